/* src/c8ie_pkg.sv */
// Shared types, constants and font table for the CHIP-8 executor.
`default_nettype none
package c8ie_pkg;

	localparam int MEM_AW          = 12;
	localparam int MEM_BYTES       = 4096;
	localparam int FRAME_AW        = 11;
	localparam int FRAME_PIXELS    = 2048;
	localparam int REG_AW          = 4;
	localparam int REG_COUNT       = 16;
	localparam int STACK_SLOTS_DEF = 12;
	localparam int FONT_LEN        = 80;

	localparam logic [11:0] START_PC = 12'h200;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_EXEC = 2'd1,
		OP_READ = 2'd2,
		OP_NOP  = 2'd3
	} opcode_t;

	// instruction groups (top nibble)
	localparam logic [3:0] G_SYS  = 4'h0;
	localparam logic [3:0] G_JP   = 4'h1;
	localparam logic [3:0] G_CALL = 4'h2;
	localparam logic [3:0] G_SE   = 4'h3;
	localparam logic [3:0] G_SNE  = 4'h4;
	localparam logic [3:0] G_SER  = 4'h5;
	localparam logic [3:0] G_LD   = 4'h6;
	localparam logic [3:0] G_ADD  = 4'h7;
	localparam logic [3:0] G_ALU  = 4'h8;
	localparam logic [3:0] G_SNER = 4'h9;
	localparam logic [3:0] G_LDI  = 4'hA;
	localparam logic [3:0] G_JPV  = 4'hB;
	localparam logic [3:0] G_RND  = 4'hC;
	localparam logic [3:0] G_DRW  = 4'hD;
	localparam logic [3:0] G_KEY  = 4'hE;
	localparam logic [3:0] G_MISC = 4'hF;

	// ALU sub-codes (low nibble of 8XYN)
	localparam logic [3:0] ALU_MOV  = 4'h0;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_ADD  = 4'h4;
	localparam logic [3:0] ALU_SUB  = 4'h5;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL  = 4'hE;

	// low-byte codes
	localparam logic [7:0] NN_CLS  = 8'hE0;
	localparam logic [7:0] NN_RET  = 8'hEE;
	localparam logic [7:0] NN_SKP  = 8'h9E;
	localparam logic [7:0] NN_SKNP = 8'hA1;
	localparam logic [7:0] NN_WKEY = 8'h0A;
	localparam logic [7:0] NN_ADDI = 8'h1E;
	localparam logic [7:0] NN_GDT  = 8'h07;
	localparam logic [7:0] NN_SDT  = 8'h15;
	localparam logic [7:0] NN_SST  = 8'h18;
	localparam logic [7:0] NN_FONT = 8'h29;
	localparam logic [7:0] NN_BCD  = 8'h33;

	localparam logic [7:0] FONT [FONT_LEN] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_LOAD, S_PIX_RD, S_PIX_CAP,
		S_FH, S_FL, S_RX, S_RY, S_R0, S_EXEC,
		S_CLR, S_DR_MEM, S_DR_LINE, S_DR_PRD, S_DR_PWR,
		S_BCD, S_WF, S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic        latch_in;
		logic        init_wr;
		logic [11:0] cnt;
		logic        mem_wr_load;
		logic        mem_rd_pc;
		logic        mem_rd_pc1;
		logic        cap_hi;
		logic        cap_word;
		logic        cap_vx;
		logic        cap_vy;
		logic        exec;
		logic        wr_flag;
		logic        frm_rd_pix;
		logic        cap_pix;
		logic        frm_clr;
		logic        mem_rd_spr;
		logic        cap_line;
		logic        frm_rd_spr;
		logic        frm_wr_spr;
		logic [3:0]  row;
		logic [2:0]  col;
		logic        mem_wr_bcd;
		logic [1:0]  bcd_idx;
		logic        out_load;
	} cmd_t;

	typedef struct packed {
		logic is_clear;
		logic is_draw;
		logic draw_empty;
		logic is_bcd;
		logic is_flag;
		logic col_last;
		logic row_last;
	} status_t;

endpackage
`default_nettype wire

/* src/c8ie_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module c8ie_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

/* src/c8ie_ctrl.sv */
// Sequencer for the CHIP-8 executor: state, loop counters and output valid.
`default_nettype none
module c8ie_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        opcode,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire c8ie_pkg::status_t status,
	output c8ie_pkg::cmd_t         cmd
);
	c8ie_pkg::ctrl_state_t state_q, state_d;
	logic [11:0] cnt_q, cnt_d;
	logic [3:0]  row_q, row_d;
	logic [2:0]  col_q, col_d;
	logic [1:0]  bcd_q, bcd_d;
	logic        out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= c8ie_pkg::S_INIT;
			cnt_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			bcd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			row_q       <= row_d;
			col_q       <= col_d;
			bcd_q       <= bcd_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		row_d       = row_q;
		col_d       = col_q;
		bcd_d       = bcd_q;
		out_valid_d = out_valid_q & ~out_ready;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.cnt     = cnt_q;
		cmd.row     = row_q;
		cmd.col     = col_q;
		cmd.bcd_idx = bcd_q;
		unique case (state_q)
			c8ie_pkg::S_INIT: begin
				cmd.init_wr = 1'b1;
				cnt_d = cnt_q + 12'd1;
				if (&cnt_q) begin
					state_d = c8ie_pkg::S_IDLE;
				end
			end
			c8ie_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					unique case (c8ie_pkg::opcode_t'(opcode))
						c8ie_pkg::OP_LOAD: state_d = c8ie_pkg::S_LOAD;
						c8ie_pkg::OP_EXEC: state_d = c8ie_pkg::S_FH;
						c8ie_pkg::OP_READ: state_d = c8ie_pkg::S_PIX_RD;
						default:           state_d = c8ie_pkg::S_DONE;
					endcase
				end
			end
			c8ie_pkg::S_LOAD: begin
				cmd.mem_wr_load = 1'b1;
				state_d = c8ie_pkg::S_DONE;
			end
			c8ie_pkg::S_PIX_RD: begin
				cmd.frm_rd_pix = 1'b1;
				state_d = c8ie_pkg::S_PIX_CAP;
			end
			c8ie_pkg::S_PIX_CAP: begin
				cmd.cap_pix = 1'b1;
				state_d = c8ie_pkg::S_DONE;
			end
			c8ie_pkg::S_FH: begin
				cmd.mem_rd_pc = 1'b1;
				state_d = c8ie_pkg::S_FL;
			end
			c8ie_pkg::S_FL: begin
				cmd.mem_rd_pc1 = 1'b1;
				cmd.cap_hi = 1'b1;
				state_d = c8ie_pkg::S_RX;
			end
			c8ie_pkg::S_RX: begin
				cmd.cap_word = 1'b1;
				state_d = c8ie_pkg::S_RY;
			end
			c8ie_pkg::S_RY: begin
				cmd.cap_vx = 1'b1;
				state_d = c8ie_pkg::S_R0;
			end
			c8ie_pkg::S_R0: begin
				cmd.cap_vy = 1'b1;
				state_d = c8ie_pkg::S_EXEC;
			end
			c8ie_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				if (status.is_clear) begin
					cnt_d = '0;
					state_d = c8ie_pkg::S_CLR;
				end else if (status.is_draw) begin
					row_d = '0;
					col_d = '0;
					state_d = status.draw_empty ? c8ie_pkg::S_WF : c8ie_pkg::S_DR_MEM;
				end else if (status.is_bcd) begin
					bcd_d = '0;
					state_d = c8ie_pkg::S_BCD;
				end else if (status.is_flag) begin
					state_d = c8ie_pkg::S_WF;
				end else begin
					state_d = c8ie_pkg::S_DONE;
				end
			end
			c8ie_pkg::S_CLR: begin
				cmd.frm_clr = 1'b1;
				cnt_d = cnt_q + 12'd1;
				if (&cnt_q[c8ie_pkg::FRAME_AW-1:0]) begin
					state_d = c8ie_pkg::S_DONE;
				end
			end
			c8ie_pkg::S_DR_MEM: begin
				cmd.mem_rd_spr = 1'b1;
				state_d = c8ie_pkg::S_DR_LINE;
			end
			c8ie_pkg::S_DR_LINE: begin
				cmd.cap_line = 1'b1;
				state_d = c8ie_pkg::S_DR_PRD;
			end
			c8ie_pkg::S_DR_PRD: begin
				cmd.frm_rd_spr = 1'b1;
				state_d = c8ie_pkg::S_DR_PWR;
			end
			c8ie_pkg::S_DR_PWR: begin
				cmd.frm_wr_spr = 1'b1;
				if (status.col_last) begin
					if (status.row_last) begin
						state_d = c8ie_pkg::S_WF;
					end else begin
						row_d = row_q + 4'd1;
						col_d = '0;
						state_d = c8ie_pkg::S_DR_MEM;
					end
				end else begin
					col_d = col_q + 3'd1;
					state_d = c8ie_pkg::S_DR_PRD;
				end
			end
			c8ie_pkg::S_BCD: begin
				cmd.mem_wr_bcd = 1'b1;
				bcd_d = bcd_q + 2'd1;
				if (bcd_q == 2'd2) begin
					state_d = c8ie_pkg::S_DONE;
				end
			end
			c8ie_pkg::S_WF: begin
				cmd.wr_flag = 1'b1;
				state_d = c8ie_pkg::S_DONE;
			end
			c8ie_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d = 1'b1;
					state_d = c8ie_pkg::S_IDLE;
				end
			end
			default: state_d = c8ie_pkg::S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

/* src/c8ie_dp.sv */
// Datapath: architectural registers, memories, instruction execute and result register.
`default_nettype none
module c8ie_dp #(
	parameter int STACK_SLOTS = c8ie_pkg::STACK_SLOTS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire c8ie_pkg::cmd_t cmd,
	output c8ie_pkg::status_t   status,
	input  wire logic [11:0]    address,
	input  wire logic [7:0]     load_byte,
	input  wire logic [15:0]    keys_down,
	input  wire logic [7:0]     random_byte,
	output logic      [11:0]    program_counter,
	output logic      [15:0]    index_value,
	output logic      [15:0]    fetched_word,
	output logic      [7:0]     read_value,
	output logic      [7:0]     flag_register,
	output logic                waiting_key,
	output logic                stack_fault,
	output logic      [7:0]     sound_level
);
	localparam int SP_W  = $clog2(STACK_SLOTS);
	localparam int LVL_W = $clog2(STACK_SLOTS + 1);

	// latched item
	logic [11:0] address_q;
	logic [7:0]  load_byte_q, rnd_q;
	logic [15:0] keys_q;

	// architectural state
	logic [11:0]      pc_q;
	logic [15:0]      index_q;
	logic [LVL_W-1:0] level_q;
	logic [7:0]       delay_q, sound_q, vf_q;
	logic [11:0]      stack_q [STACK_SLOTS];

	// working registers
	logic [7:0]  hi_q, vx_q, vy_q, line_q, flag_val_q;
	logic [15:0] word_q, rep_word_q;
	logic        pix_q, wait_q, fault_q;

	// result register
	logic [11:0] pc_out_q;
	logic [15:0] idx_out_q, word_out_q;
	logic [7:0]  pix_out_q, vf_out_q, snd_out_q;
	logic        wait_out_q, fault_out_q;

	// memories
	logic                              mem_we;
	logic [c8ie_pkg::MEM_AW-1:0]       mem_waddr, mem_raddr;
	logic [7:0]                        mem_wdata, mem_rdata;
	logic                              frm_we;
	logic [c8ie_pkg::FRAME_AW-1:0]     frm_waddr, frm_raddr;
	logic                              frm_wdata, frm_rdata;
	logic                              reg_we;
	logic [c8ie_pkg::REG_AW-1:0]       reg_waddr, reg_raddr;
	logic [7:0]                        reg_wdata, reg_rdata;

	c8ie_ram #(.WIDTH(8), .DEPTH(c8ie_pkg::MEM_BYTES)) u_main_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);
	c8ie_ram #(.WIDTH(1), .DEPTH(c8ie_pkg::FRAME_PIXELS)) u_frame (
		.clk(clk), .we(frm_we), .waddr(frm_waddr), .wdata(frm_wdata),
		.raddr(frm_raddr), .rdata(frm_rdata)
	);
	c8ie_ram #(.WIDTH(8), .DEPTH(c8ie_pkg::REG_COUNT)) u_vregs (
		.clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
		.raddr(reg_raddr), .rdata(reg_rdata)
	);

	// instruction fields
	logic [3:0]  w_grp, w_x, w_n;
	logic [7:0]  w_nn;
	logic [11:0] w_nnn;
	assign w_grp = word_q[15:12];
	assign w_x   = word_q[11:8];
	assign w_n   = word_q[3:0];
	assign w_nn  = word_q[7:0];
	assign w_nnn = word_q[11:0];

	logic [11:0] pc_plus2, pc_minus2;
	assign pc_plus2  = pc_q + 12'd2;
	assign pc_minus2 = pc_q - 12'd2;

	logic [LVL_W-1:0] lvl_dec;
	logic [SP_W-1:0]  pop_idx, push_idx;
	assign lvl_dec  = level_q - LVL_W'(1);
	assign pop_idx  = lvl_dec[SP_W-1:0];
	assign push_idx = level_q[SP_W-1:0];

	logic key_dn;
	assign key_dn = (vx_q[7:4] == 4'd0) && keys_q[vx_q[3:0]];

	logic [3:0] key_low;
	always_comb begin
		key_low = '0;
		for (int k = 15; k >= 0; k--) begin
			if (keys_q[k]) key_low = 4'(k);
		end
	end

	// execute
	logic [11:0]      pc_ex;
	logic [15:0]      idx_ex;
	logic [LVL_W-1:0] lvl_ex;
	logic [7:0]       dly_ex, snd_ex, wx_val;
	logic             wx_en, flg_ex, push, fault_ex, wait_ex;
	logic             is_clear, is_draw, is_bcd, is_flag;
	logic [8:0]       sum9;

	assign sum9 = {1'b0, vx_q} + {1'b0, vy_q};

	always_comb begin
		pc_ex    = pc_q;
		idx_ex   = index_q;
		lvl_ex   = level_q;
		dly_ex   = delay_q;
		snd_ex   = sound_q;
		wx_en    = 1'b0;
		wx_val   = vx_q;
		flg_ex   = 1'b0;
		push     = 1'b0;
		fault_ex = 1'b0;
		wait_ex  = 1'b0;
		is_clear = 1'b0;
		is_draw  = 1'b0;
		is_bcd   = 1'b0;
		is_flag  = 1'b0;
		unique case (w_grp)
			c8ie_pkg::G_SYS: begin
				if (w_nn == c8ie_pkg::NN_CLS) begin
					is_clear = 1'b1;
				end else if (w_nn == c8ie_pkg::NN_RET) begin
					if (level_q == '0) begin
						fault_ex = 1'b1;
					end else begin
						lvl_ex = lvl_dec;
						pc_ex  = stack_q[pop_idx];
					end
				end
			end
			c8ie_pkg::G_JP: pc_ex = w_nnn;
			c8ie_pkg::G_CALL: begin
				if (level_q >= LVL_W'(STACK_SLOTS)) begin
					fault_ex = 1'b1;
				end else begin
					push   = 1'b1;
					lvl_ex = level_q + LVL_W'(1);
					pc_ex  = w_nnn;
				end
			end
			c8ie_pkg::G_SE:   if (vx_q == w_nn) pc_ex = pc_plus2;
			c8ie_pkg::G_SNE:  if (vx_q != w_nn) pc_ex = pc_plus2;
			c8ie_pkg::G_SER:  if (w_n == 4'd0 && vx_q == vy_q) pc_ex = pc_plus2;
			c8ie_pkg::G_LD: begin
				wx_en  = 1'b1;
				wx_val = w_nn;
			end
			c8ie_pkg::G_ADD: begin
				wx_en  = 1'b1;
				wx_val = vx_q + w_nn;
			end
			c8ie_pkg::G_ALU: begin
				case (w_n)
					c8ie_pkg::ALU_MOV: begin wx_en = 1'b1; wx_val = vy_q; end
					c8ie_pkg::ALU_OR:  begin wx_en = 1'b1; wx_val = vx_q | vy_q; end
					c8ie_pkg::ALU_AND: begin wx_en = 1'b1; wx_val = vx_q & vy_q; end
					c8ie_pkg::ALU_XOR: begin wx_en = 1'b1; wx_val = vx_q ^ vy_q; end
					c8ie_pkg::ALU_ADD: begin
						wx_en = 1'b1; wx_val = sum9[7:0];
						flg_ex = sum9[8]; is_flag = 1'b1;
					end
					c8ie_pkg::ALU_SUB: begin
						wx_en = 1'b1; wx_val = vx_q - vy_q;
						flg_ex = (vx_q >= vy_q); is_flag = 1'b1;
					end
					c8ie_pkg::ALU_SHR: begin
						wx_en = 1'b1; wx_val = {1'b0, vx_q[7:1]};
						flg_ex = vx_q[0]; is_flag = 1'b1;
					end
					c8ie_pkg::ALU_SUBN: begin
						wx_en = 1'b1; wx_val = vy_q - vx_q;
						flg_ex = (vy_q >= vx_q); is_flag = 1'b1;
					end
					c8ie_pkg::ALU_SHL: begin
						wx_en = 1'b1; wx_val = {vx_q[6:0], 1'b0};
						flg_ex = vx_q[7]; is_flag = 1'b1;
					end
					default: ;
				endcase
			end
			c8ie_pkg::G_SNER: if (vx_q != vy_q) pc_ex = pc_plus2;
			c8ie_pkg::G_LDI:  idx_ex = {4'd0, w_nnn};
			c8ie_pkg::G_JPV:  pc_ex = {4'd0, reg_rdata} + w_nnn;  // V0 arrives this cycle
			c8ie_pkg::G_RND: begin
				wx_en  = 1'b1;
				wx_val = rnd_q & w_nn;
			end
			c8ie_pkg::G_DRW: is_draw = 1'b1;
			c8ie_pkg::G_KEY: begin
				if (w_nn == c8ie_pkg::NN_SKP && key_dn) pc_ex = pc_plus2;
				if (w_nn == c8ie_pkg::NN_SKNP && !key_dn) pc_ex = pc_plus2;
			end
			c8ie_pkg::G_MISC: begin
				case (w_nn)
					c8ie_pkg::NN_WKEY: begin
						if (|keys_q) begin
							wx_en  = 1'b1;
							wx_val = {4'd0, key_low};
						end else begin
							pc_ex   = pc_minus2;
							wait_ex = 1'b1;
						end
					end
					c8ie_pkg::NN_ADDI: idx_ex = index_q + {8'd0, vx_q};
					c8ie_pkg::NN_GDT: begin
						wx_en  = 1'b1;
						wx_val = delay_q;
					end
					c8ie_pkg::NN_SDT:  dly_ex = vx_q;
					c8ie_pkg::NN_SST:  snd_ex = vx_q;
					c8ie_pkg::NN_FONT: idx_ex = {6'd0, vx_q, 2'd0} + {8'd0, vx_q};
					c8ie_pkg::NN_BCD:  is_bcd = 1'b1;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// sprite geometry
	logic [5:0]  xpos;
	logic [4:0]  ypos;
	logic [10:0] pix_addr;
	logic        spr_bit;
	assign xpos     = vx_q[5:0] + {3'd0, cmd.col};
	assign ypos     = vy_q[4:0] + {1'b0, cmd.row};
	assign pix_addr = {ypos, xpos};
	assign spr_bit  = line_q[3'd7 - cmd.col];

	always_comb begin
		status            = '0;
		status.is_clear   = is_clear;
		status.is_draw    = is_draw;
		status.draw_empty = (w_n == 4'd0);
		status.is_bcd     = is_bcd;
		status.is_flag    = is_flag;
		status.col_last   = (cmd.col == 3'd7) || (xpos == 6'd63);
		status.row_last   = ({1'b0, cmd.row} + 5'd1 == {1'b0, w_n}) || (ypos == 5'd31);
	end

	// BCD digits: hundreds by compare, tens by reciprocal multiply
	logic [1:0]  bcd_h;
	logic [6:0]  bcd_rem;
	logic [14:0] bcd_prod;
	logic [3:0]  bcd_t, bcd_o;
	logic [7:0]  bcd_digit;
	always_comb begin
		if (vx_q >= 8'd200) begin
			bcd_h   = 2'd2;
			bcd_rem = 7'(vx_q - 8'd200);
		end else if (vx_q >= 8'd100) begin
			bcd_h   = 2'd1;
			bcd_rem = 7'(vx_q - 8'd100);
		end else begin
			bcd_h   = 2'd0;
			bcd_rem = vx_q[6:0];
		end
		bcd_prod = {8'd0, bcd_rem} * 15'd205;
		bcd_t    = bcd_prod[14:11];
		bcd_o    = 4'(bcd_rem - {3'd0, bcd_t} * 7'd10);
		case (cmd.bcd_idx)
			2'd0:    bcd_digit = {6'd0, bcd_h};
			2'd1:    bcd_digit = {4'd0, bcd_t};
			default: bcd_digit = {4'd0, bcd_o};
		endcase
	end

	// main memory ports
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = address_q;
		mem_wdata = load_byte_q;
		if (cmd.init_wr) begin
			mem_we    = 1'b1;
			mem_waddr = cmd.cnt;
			mem_wdata = (cmd.cnt < 12'(c8ie_pkg::FONT_LEN)) ?
				c8ie_pkg::FONT[cmd.cnt[6:0]] : 8'd0;
		end else if (cmd.mem_wr_load) begin
			mem_we = 1'b1;
		end else if (cmd.mem_wr_bcd) begin
			mem_we    = 1'b1;
			mem_waddr = index_q[11:0] + {10'd0, cmd.bcd_idx};
			mem_wdata = bcd_digit;
		end
		if (cmd.mem_rd_pc1) begin
			mem_raddr = pc_q + 12'd1;
		end else if (cmd.mem_rd_spr) begin
			mem_raddr = index_q[11:0] + {8'd0, cmd.row};
		end else begin
			mem_raddr = pc_q;
		end
	end

	// frame ports
	always_comb begin
		frm_we    = 1'b0;
		frm_waddr = pix_addr;
		frm_wdata = frm_rdata ^ spr_bit;
		if (cmd.init_wr || cmd.frm_clr) begin
			frm_we    = 1'b1;
			frm_waddr = cmd.cnt[c8ie_pkg::FRAME_AW-1:0];
			frm_wdata = 1'b0;
		end else if (cmd.frm_wr_spr) begin
			frm_we = 1'b1;
		end
		frm_raddr = cmd.frm_rd_pix ? address_q[c8ie_pkg::FRAME_AW-1:0] : pix_addr;
	end

	// register file ports
	always_comb begin
		reg_we    = 1'b0;
		reg_waddr = w_x;
		reg_wdata = wx_val;
		if (cmd.init_wr) begin
			reg_we    = 1'b1;
			reg_waddr = cmd.cnt[c8ie_pkg::REG_AW-1:0];
			reg_wdata = 8'd0;
		end else if (cmd.exec && wx_en) begin
			reg_we = 1'b1;
		end else if (cmd.wr_flag) begin
			reg_we    = 1'b1;
			reg_waddr = 4'hF;
			reg_wdata = flag_val_q;
		end
		if (cmd.cap_word) begin
			reg_raddr = hi_q[3:0];
		end else if (cmd.cap_vx) begin
			reg_raddr = word_q[7:4];
		end else begin
			reg_raddr = 4'd0;
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= c8ie_pkg::START_PC;
			index_q <= '0;
			level_q <= '0;
			delay_q <= '0;
			sound_q <= '0;
			vf_q    <= '0;
		end else begin
			if (cmd.cap_word) begin
				pc_q <= pc_plus2;
			end else if (cmd.exec) begin
				pc_q    <= pc_ex;
				index_q <= idx_ex;
				level_q <= lvl_ex;
				delay_q <= dly_ex;
				sound_q <= snd_ex;
			end
			if (reg_we && reg_waddr == 4'hF) begin
				vf_q <= reg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && push) begin
			stack_q[push_idx] <= pc_q;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			address_q   <= address;
			load_byte_q <= load_byte;
			keys_q      <= keys_down;
			rnd_q       <= random_byte;
			rep_word_q  <= '0;
			pix_q       <= 1'b0;
			wait_q      <= 1'b0;
			fault_q     <= 1'b0;
		end
		if (cmd.cap_hi)   hi_q <= mem_rdata;
		if (cmd.cap_word) begin
			word_q     <= {hi_q, mem_rdata};
			rep_word_q <= {hi_q, mem_rdata};
		end
		if (cmd.cap_vx)   vx_q <= reg_rdata;
		if (cmd.cap_vy)   vy_q <= reg_rdata;
		if (cmd.exec) begin
			flag_val_q <= {7'd0, flg_ex};
			wait_q     <= wait_ex;
			fault_q    <= fault_ex;
		end
		if (cmd.cap_line) line_q <= mem_rdata;
		if (cmd.frm_wr_spr) begin
			flag_val_q <= flag_val_q | {7'd0, spr_bit & frm_rdata};
		end
		if (cmd.cap_pix) begin
			pix_q <= ~address_q[11] & frm_rdata;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pc_out_q    <= pc_q;
			idx_out_q   <= index_q;
			word_out_q  <= rep_word_q;
			pix_out_q   <= {7'd0, pix_q};
			vf_out_q    <= vf_q;
			wait_out_q  <= wait_q;
			fault_out_q <= fault_q;
			snd_out_q   <= sound_q;
		end
	end

	assign program_counter = pc_out_q;
	assign index_value     = idx_out_q;
	assign fetched_word    = word_out_q;
	assign read_value      = pix_out_q;
	assign flag_register   = vf_out_q;
	assign waiting_key     = wait_out_q;
	assign stack_fault     = fault_out_q;
	assign sound_level     = snd_out_q;
endmodule
`default_nettype wire

/* src/chip8_instruction_executor_core.sv */
// Top level of the CHIP-8 executor: sequencer plus datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------------
//  in      | in_valid / in_ready  | opcode, address, load_byte, keys_down, random_byte
//  out     | out_valid / out_ready| program_counter, index_value, fetched_word,
//          |                      | read_value, flag_register, waiting_key,
//          |                      | stack_fault, sound_level
//
// From accept to result, each item steps through sequencer states: load,
// pixel read, no-op, plain instruction (plus a VF write when VF is written),
// BCD (three digit writes), 00E0 (one frame pixel per cycle), sprite draw
// (a byte fetch per row, a read and a write per drawn pixel). Every byte
// and pixel goes through one registered RAM read port, one access per cycle.
// After reset an init pass over all 4096 memory addresses loads the font, zeroes
// memory, frame and V registers; in_ready stays low during it.
// One item is in work at a time. The result sits in an output register, so
// a stalled out_ready only blocks once a second result is ready.
`default_nettype none
module chip8_instruction_executor_core #(
	parameter int STACK_SLOTS = c8ie_pkg::STACK_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [11:0] address,
	input  wire logic [7:0]  load_byte,
	input  wire logic [15:0] keys_down,
	input  wire logic [7:0]  random_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [11:0] program_counter,
	output logic      [15:0] index_value,
	output logic      [15:0] fetched_word,
	output logic      [7:0]  read_value,
	output logic      [7:0]  flag_register,
	output logic             waiting_key,
	output logic             stack_fault,
	output logic      [7:0]  sound_level
);
	c8ie_pkg::cmd_t    cmd;
	c8ie_pkg::status_t status;

	// sequencer: owns handshakes, loop counters and the init/clear sweeps
	c8ie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: memory, frame, V registers, PC/I/stack/timers, result register
	c8ie_dp #(.STACK_SLOTS(STACK_SLOTS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.address         (address),
		.load_byte       (load_byte),
		.keys_down       (keys_down),
		.random_byte     (random_byte),
		.program_counter (program_counter),
		.index_value     (index_value),
		.fetched_word    (fetched_word),
		.read_value      (read_value),
		.flag_register   (flag_register),
		.waiting_key     (waiting_key),
		.stack_fault     (stack_fault),
		.sound_level     (sound_level)
	);
endmodule
`default_nettype wire
